// File: hdl/crmf_pkg.sv
// shared types and constants of the cross median-of-five filter
package crmf_pkg;

	localparam int PW             = 23;   // position counters
	localparam int TW             = 24;   // pixels per frame
	localparam int WW             = 11;   // frame width register
	localparam int HW             = 13;   // frame height register
	localparam int CH_W           = 8;    // one color sample
	localparam int NUM_LANES      = 3;    // red, green, blue
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT     = 4096;
	localparam int RESET_WIDTH    = 640;
	localparam int RESET_HEIGHT   = 480;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// lane 0 red, lane 1 green, lane 2 blue
	typedef logic [NUM_LANES-1:0][CH_W-1:0] pix_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} lb_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_TOTAL,
		SEQ_SUM,
		SEQ_WRAP,
		SEQ_DIV
	} seq_state_t;

endpackage

// File: hdl/crmf_med5_lane.sv
// one color lane: median of the five-point cross, or the center at a border
module crmf_med5_lane (
	input  logic [crmf_pkg::CH_W-1:0] left,
	input  logic [crmf_pkg::CH_W-1:0] center,
	input  logic [crmf_pkg::CH_W-1:0] right,
	input  logic [crmf_pkg::CH_W-1:0] top,
	input  logic [crmf_pkg::CH_W-1:0] bottom,
	input  logic                      inner,
	output logic [crmf_pkg::CH_W-1:0] y
);
	import crmf_pkg::*;

	logic [CH_W-1:0] min_lr, max_lr, min_tb, max_tb;
	logic [CH_W-1:0] lo, hi, min_cl, max_cl, mid_hi, med;

	always_comb begin
		min_lr = (left < right) ? left : right;
		max_lr = (left < right) ? right : left;
		min_tb = (top < bottom) ? top : bottom;
		max_tb = (top < bottom) ? bottom : top;
		// larger of the pair minima, smaller of the pair maxima
		lo     = (min_lr > min_tb) ? min_lr : min_tb;
		hi     = (max_lr < max_tb) ? max_lr : max_tb;
		// median of center, lo and hi
		min_cl = (center < lo) ? center : lo;
		max_cl = (center < lo) ? lo : center;
		mid_hi = (max_cl < hi) ? max_cl : hi;
		med    = (min_cl > mid_hi) ? min_cl : mid_hi;
		y      = inner ? med : center;
	end

endmodule

// File: hdl/crmf_line_buf.sv
// two line stores with registered reads and same-column forwarding
module crmf_line_buf #(
	parameter int DEPTH = crmf_pkg::DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  crmf_pkg::lb_ctrl_t ctrl,
	input  logic [AW-1:0]      rd_addr,
	input  logic [AW-1:0]      wr_addr,
	input  crmf_pkg::pix_t     wr_data,
	output crmf_pkg::pix_t     above1,
	output crmf_pkg::pix_t     above2
);
	import crmf_pkg::*;

	pix_t lower_mem [DEPTH];
	pix_t upper_mem [DEPTH];
	pix_t rd_lower_q, rd_upper_q, last_x_q, last_a_q;
	logic fwd_q;

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_lower_q <= lower_mem[rd_addr];
			rd_upper_q <= upper_mem[rd_addr];
		end
		if (ctrl.wr_en) begin
			lower_mem[wr_addr] <= wr_data;
			upper_mem[wr_addr] <= above1;
			last_x_q           <= wr_data;
			last_a_q           <= above1;
		end
	end

	// read and write of the same column at one edge: read saw stale data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctrl.rd_en) begin
			fwd_q <= ctrl.wr_en && (rd_addr == wr_addr);
		end
	end

	assign above1 = fwd_q ? last_x_q : rd_lower_q;
	assign above2 = fwd_q ? last_a_q : rd_upper_q;

endmodule

// File: hdl/crmf_divider.sv
// restoring divider, one quotient bit per cycle, for position to row and column
module crmf_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [crmf_pkg::PW-1:0] dividend,
	input  logic [crmf_pkg::WW-1:0] divisor,
	output crmf_pkg::div_stat_t     stat,
	output logic [crmf_pkg::PW-1:0] quotient,
	output logic [crmf_pkg::WW-1:0] remainder
);
	import crmf_pkg::*;

	localparam int CNT_W = $clog2(PW);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    dvd_q, quo_q;
	logic [WW-1:0]    rem_q, rem_nxt;
	logic [WW:0]      trial;
	logic             ge;

	always_comb begin
		trial   = {rem_q, dvd_q[PW-1]};
		ge      = trial >= {1'b0, divisor};
		rem_nxt = ge ? WW'(trial - {1'b0, divisor}) : trial[WW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PW-2:0], 1'b0};
			rem_q <= rem_nxt;
			quo_q <= {quo_q[PW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hdl/cross_median_of_five_filter.sv
// top level of the five-point cross median filter for raster rgb pixels
//
// usage
// - input channel (in_valid/in_ready): one pixel per transfer in raster order,
//   drain = 1 marks a flush item with no pixel; after the last pixel of a frame
//   send frame_width + 1 drain items to push out the remaining results
// - output channel (out_valid/out_ready): one filtered pixel per transfer,
//   frame_end = 1 on the last pixel of the frame
// - config channel (cfg_valid/cfg_ready): index 0 frame_width, 1 frame_height,
//   write only while no results are pending
// - throughput: one item per cycle while in_ready is high; a result goes from
//   its transfer through the line store read, then the median lanes, to out_valid
// - each result leaves with the input item that arrives one row plus one
//   pixel after its own pixel
// - after reset and after every config write the row/column counters are
//   rebuilt: the frame size first, then row and column in the bit-serial
//   divider, during which in_ready is low
// - a stalled receiver holds the output register; the pipeline keeps taking
//   items until every stage in front of it is full
module cross_median_of_five_filter #(
	parameter int MAX_WIDTH = crmf_pkg::DEF_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            drain,
	input  logic [crmf_pkg::CH_W-1:0]       red_in,
	input  logic [crmf_pkg::CH_W-1:0]       green_in,
	input  logic [crmf_pkg::CH_W-1:0]       blue_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [crmf_pkg::CH_W-1:0]       red_out,
	output logic [crmf_pkg::CH_W-1:0]       green_out,
	output logic [crmf_pkg::CH_W-1:0]       blue_out,
	output logic                            frame_end,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crmf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import crmf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = ((CW > WW) ? CW : WW) + 1;

	// configuration and derived frame size
	logic [WW-1:0] frame_width_q;
	logic [HW-1:0] frame_height_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [TW-1:0] total_q;
	logic [TW:0]   tpw_q;      // total pixels plus one row of flush
	logic          cfg_acc;

	// recompute sequencer
	seq_state_t seq_state, seq_next;
	logic       seq_idle, do_total, do_sum, do_wrap;
	logic       wrap_needed;
	logic [PW-1:0] div_dividend, div_quo;
	logic [WW-1:0] div_rem;
	div_stat_t     div_stat;

	// input position: linear count plus row and column
	logic [PW-1:0] pos_q, pr_q;
	logic [CW-1:0] pc_q;

	// accept-time decode
	pix_t          pix_in, x_new;
	logic          acc, ld1, in_frame, ignored;
	logic          emit_new, end_new, inner_new, pc_wrap;
	logic [XW-1:0] pc_x, w_x, qc_x;
	logic [PW-1:0] qr;

	// pipeline
	logic          rdy_o, rdy2, rdy1, mv1, mv2;
	logic          v1_q, v2_q, out_valid_q;
	pix_t          x_s1;
	logic [CW-1:0] addr_s1;
	logic          emit_s1, inner_s1, end_s1;
	pix_t          above1, above2;
	lb_ctrl_t      lb_ctrl;
	pix_t          win_l_q, win_c_q, win_t_q, win_b_q;
	pix_t          l_s2, c_s2, r_s2, t_s2, b_s2;
	logic          inner_s2, end_s2;
	pix_t          lane_y;
	logic [CH_W-1:0] red_out_q, green_out_q, blue_out_q;
	logic          frame_end_q;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WW'(RESET_WIDTH);
			frame_height_q <= HW'(RESET_HEIGHT);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[WW-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		if (frame_width_q == '0)
			w_eff = WW'(1);
		else if (32'(frame_width_q) > 32'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = frame_width_q;
		if (frame_height_q == '0)
			h_eff = HW'(1);
		else if (32'(frame_height_q) > 32'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = frame_height_q;
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_state <= SEQ_TOTAL;
		end else begin
			seq_state <= seq_next;
		end
	end

	always_comb begin
		seq_next = seq_state;
		unique case (seq_state)
			SEQ_IDLE:  seq_next = SEQ_IDLE;
			SEQ_TOTAL: seq_next = SEQ_SUM;
			SEQ_SUM:   seq_next = SEQ_WRAP;
			SEQ_WRAP:  seq_next = SEQ_DIV;
			SEQ_DIV:   seq_next = div_stat.done ? SEQ_IDLE : SEQ_DIV;
			default:   seq_next = SEQ_TOTAL;
		endcase
		// a new write restarts the whole rebuild
		if (cfg_acc)
			seq_next = SEQ_TOTAL;
	end

	always_comb begin
		seq_idle = 1'b0;
		do_total = 1'b0;
		do_sum   = 1'b0;
		do_wrap  = 1'b0;
		unique case (seq_state)
			SEQ_IDLE:  seq_idle = 1'b1;
			SEQ_TOTAL: do_total = 1'b1;
			SEQ_SUM:   do_sum   = 1'b1;
			SEQ_WRAP:  do_wrap  = 1'b1;
			SEQ_DIV:   ;
			default:   ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_total)
			total_q <= TW'(w_eff) * TW'(h_eff);
		if (do_sum)
			tpw_q <= (TW+1)'(total_q) + (TW+1)'(w_eff);
	end

	// position beyond frame plus flush after a size change: back to frame start
	assign wrap_needed  = (TW+1)'(pos_q) > tpw_q;
	assign div_dividend = wrap_needed ? '0 : pos_q;

	crmf_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (do_wrap),
		.dividend  (div_dividend),
		.divisor   (w_eff),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// ---------------------------------------------------------- accept decode
	assign pix_in = {blue_in, green_in, red_in};
	assign acc    = in_valid && in_ready;

	always_comb begin
		pc_x      = XW'(pc_q);
		w_x       = XW'(w_eff);
		in_frame  = TW'(pos_q) < total_q;
		ignored   = drain && in_frame;
		x_new     = (!drain && in_frame) ? pix_in : '0;
		// a result leaves once one row plus one pixel has come in
		emit_new  = TW'(pos_q) >= (TW'(w_eff) + TW'(1));
		end_new   = (TW+1)'(pos_q) >= tpw_q;
		// row and column of the pixel that leaves now
		qc_x      = (pc_q == '0) ? (w_x - XW'(1)) : (pc_x - XW'(1));
		qr        = (pc_q == '0) ? (pr_q - PW'(2)) : (pr_q - PW'(1));
		inner_new = (qr != '0) && ((TW'(qr) + TW'(2)) <= TW'(h_eff)) &&
			(qc_x != '0) && ((qc_x + XW'(2)) <= w_x);
		pc_wrap   = pc_x == (w_x - XW'(1));
		ld1       = acc && !ignored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pr_q  <= '0;
			pc_q  <= '0;
		end else if (do_wrap && wrap_needed) begin
			pos_q <= '0;
		end else if (div_stat.done) begin
			pr_q <= div_quo;
			pc_q <= CW'(div_rem);
		end else if (ld1) begin
			if (emit_new && end_new) begin
				// last pixel of the frame leaves: start a new frame
				pos_q <= '0;
				pr_q  <= '0;
				pc_q  <= '0;
			end else begin
				pos_q <= pos_q + PW'(1);
				if (pc_wrap) begin
					pc_q <= '0;
					pr_q <= pr_q + PW'(1);
				end else begin
					pc_q <= pc_q + CW'(1);
				end
			end
		end
	end

	// -------------------------------------------------------------- pipeline
	// each stage loads when empty or when it hands its item on
	assign rdy_o    = !out_valid_q || out_ready;
	assign rdy2     = !v2_q || rdy_o;
	assign rdy1     = !v1_q || rdy2;
	assign mv1      = v1_q && rdy2;
	assign mv2      = v2_q && rdy_o;
	assign in_ready = seq_idle && rdy1 && !cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1)
				v1_q <= 1'b1;
			else if (mv1)
				v1_q <= 1'b0;
			// items that give no result only update stores and window
			if (mv1 && emit_s1)
				v2_q <= 1'b1;
			else if (mv2)
				v2_q <= 1'b0;
			if (mv2)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// stage 1: line store read in flight
	always_ff @(posedge clk) begin
		if (ld1) begin
			x_s1     <= x_new;
			addr_s1  <= pc_q;
			emit_s1  <= emit_new;
			inner_s1 <= inner_new;
			end_s1   <= end_new;
		end
	end

	assign lb_ctrl.rd_en = ld1;
	assign lb_ctrl.wr_en = mv1;

	crmf_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lb_ctrl),
		.rd_addr (pc_q),
		.wr_addr (addr_s1),
		.wr_data (x_s1),
		.above1  (above1),
		.above2  (above2)
	);

	// cross window: center one row back, top two rows back, bottom current row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l_q <= '0;
			win_c_q <= '0;
			win_t_q <= '0;
			win_b_q <= '0;
		end else if (mv1) begin
			win_l_q <= win_c_q;
			win_c_q <= above1;
			win_t_q <= above2;
			win_b_q <= x_s1;
		end
	end

	// stage 2: window operands for the lanes
	always_ff @(posedge clk) begin
		if (mv1) begin
			l_s2     <= win_l_q;
			c_s2     <= win_c_q;
			r_s2     <= above1;
			t_s2     <= win_t_q;
			b_s2     <= win_b_q;
			inner_s2 <= inner_s1;
			end_s2   <= end_s1;
		end
	end

	// one median lane per color
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		crmf_med5_lane u_lane (
			.left   (l_s2[i]),
			.center (c_s2[i]),
			.right  (r_s2[i]),
			.top    (t_s2[i]),
			.bottom (b_s2[i]),
			.inner  (inner_s2),
			.y      (lane_y[i])
		);
	end

	// merge the lanes into the output register
	always_ff @(posedge clk) begin
		if (mv2) begin
			red_out_q   <= lane_y[0];
			green_out_q <= lane_y[1];
			blue_out_q  <= lane_y[2];
			frame_end_q <= end_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_out_q;
	assign green_out = green_out_q;
	assign blue_out  = blue_out_q;
	assign frame_end = frame_end_q;

	// ------------------------------------------------------------ assertions
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (seq_state == SEQ_IDLE) && !div_stat.busy)
		else $error("input taken while counters are rebuilt");

	a_column_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_state == SEQ_IDLE) |-> (XW'(pc_q) < XW'(w_eff)))
		else $error("column counter beyond frame width");

	a_position_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_state == SEQ_IDLE) |-> ((TW+1)'(pos_q) <= tpw_q))
		else $error("position beyond frame plus flush");

endmodule

// File: bench/cross_median_of_five_filter_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the cross median-of-five filter: random rgb frames against a predictor
module cross_median_of_five_filter_tb;
	import crmf_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any transfer
	localparam int unsigned RANDOM_ITEMS   = 1750;
	localparam int unsigned REPORT_LIMIT   = 10;
	localparam int unsigned TAIL_ITEMS     = 200;   // last stretch runs without idling
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic drain;
		pix_t px;
	} stream_item_t;

	typedef struct packed {
		logic eof;
		pix_t px;
	} filtered_pixel_t;

	typedef enum int {
		SAMPLE_FULL,
		SAMPLE_EXTREME,
		SAMPLE_TIES
	} sample_style_t;

	// block ports; the inputs are known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  drain     = 1'b0;
	logic [CH_W-1:0]       red_in    = '0;
	logic [CH_W-1:0]       green_in  = '0;
	logic [CH_W-1:0]       blue_in   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CH_W-1:0]       red_out;
	logic [CH_W-1:0]       green_out;
	logic [CH_W-1:0]       blue_out;
	logic                  frame_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of the registers and the filter state
	logic [WW-1:0] width_reg  = WW'(RESET_WIDTH);
	logic [HW-1:0] height_reg = HW'(RESET_HEIGHT);
	pix_t          two_rows_up[DEF_MAX_WIDTH] = '{default: '0};
	pix_t          one_row_up[DEF_MAX_WIDTH]  = '{default: '0};
	pix_t          window[5] = '{default: '0};  // west, center, east, north, south
	int unsigned   in_pos = 0;

	// stimulus and checking bookkeeping
	stream_item_t    outgoing_items[$];
	filtered_pixel_t awaited_pixels[$];
	stream_item_t    driven_item;
	int unsigned     counted_items  = 0;
	int unsigned     pixels_sent    = 0;
	int unsigned     results_seen   = 0;
	int unsigned     frames_checked = 0;
	int unsigned     error_count    = 0;
	int unsigned     in_gap_pct     = 0;
	int unsigned     out_stall_pct  = 0;
	bit              quiet_tail     = 1'b0;
	int unsigned     gap_left       = 0;
	int unsigned     stall_left     = 0;
	int unsigned     quiet_cycles   = 0;

	cross_median_of_five_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.drain     (drain),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// register value as the block uses it: zero acts as one, large values saturate
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [CH_W-1:0] median_of_five(input logic [CH_W-1:0] a, b, c, d, e);
		logic [CH_W-1:0] s[5];
		logic [CH_W-1:0] t;
		s = '{a, b, c, d, e};
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4 - i; j++)
				if (s[j] > s[j + 1]) begin
					t        = s[j];
					s[j]     = s[j + 1];
					s[j + 1] = t;
				end
		return s[2];
	endfunction

	function automatic pix_t make_pixel(input sample_style_t style);
		pix_t px;
		px = $urandom;
		for (int l = 0; l < NUM_LANES; l++)
			case (style)
				SAMPLE_EXTREME: begin
					case ($urandom_range(3))
						0:       px[l] = 8'h00;
						1:       px[l] = 8'hFF;
						2:       px[l] = 8'h7F;
						default: px[l] = 8'h80;
					endcase
				end
				// narrow range so the median sees many equal samples
				SAMPLE_TIES: px[l] = CH_W'($urandom_range(3));
				default: ;
			endcase
		return px;
	endfunction

	// one accepted item through the line stores and the cross window
	task automatic advance_cross_filter(input stream_item_t item);
		int unsigned     cols, rows, total, p, ci, q, qr, qc;
		pix_t            x, up1, up2, west, mid, east, north, south;
		logic            inner;
		filtered_pixel_t res;
		cols  = clamp_dim(width_reg, DEF_MAX_WIDTH);
		rows  = clamp_dim(height_reg, MAX_HEIGHT);
		total = cols * rows;
		p     = in_pos;
		// position beyond frame plus flush restarts the frame
		if (p > total + cols)
			p = 0;
		// drain before the last pixel of the frame is ignored
		if (item.drain && p < total) begin
			in_pos = p;
			return;
		end
		// flush items, and pixels sent during the flush, shift in zero
		x   = (item.drain || p >= total) ? '0 : item.px;
		ci  = p % cols;
		up1 = one_row_up[ci];
		up2 = two_rows_up[ci];
		two_rows_up[ci] = up1;
		one_row_up[ci]  = x;
		west  = window[0];
		mid   = window[1];
		east  = up1;
		north = window[3];
		south = window[4];
		window[0] = mid;
		window[1] = up1;
		window[2] = east;
		window[3] = up2;
		window[4] = x;
		if (p < cols + 1) begin
			in_pos = (p + 1) % (1 << PW);
			return;
		end
		q     = p - cols - 1;
		qr    = q / cols;
		qc    = q % cols;
		inner = qr >= 1 && qr + 2 <= rows && qc >= 1 && qc + 2 <= cols;
		for (int l = 0; l < NUM_LANES; l++)
			res.px[l] = inner ? median_of_five(mid[l], west[l], east[l], north[l], south[l])
				: mid[l];
		res.eof = (q + 1 >= total);
		in_pos  = res.eof ? 0 : (p + 1) % (1 << PW);
		awaited_pixels.push_back(res);
	endtask

	task automatic push_item(input logic is_drain, input pix_t px, input bit counts);
		stream_item_t it;
		it.drain = is_drain;
		it.px    = px;
		outgoing_items.push_back(it);
		if (counts)
			counted_items++;
		if (!is_drain)
			pixels_sent++;
	endtask

	// one frame plus its flush, with ignored drains mixed in and some pixels during the flush
	task automatic queue_frame(input int unsigned noise_pct, input int unsigned flush_px_pct,
			input sample_style_t style);
		int unsigned cols, rows;
		cols = clamp_dim(width_reg, DEF_MAX_WIDTH);
		rows = clamp_dim(height_reg, MAX_HEIGHT);
		for (int k = 0; k < cols * rows; k++) begin
			if ($urandom_range(99) < noise_pct)
				push_item(1'b1, make_pixel(SAMPLE_FULL), 1'b0);
			push_item(1'b0, make_pixel(style), 1'b1);
		end
		for (int k = 0; k <= cols; k++)
			push_item($urandom_range(99) >= flush_px_pct, make_pixel(SAMPLE_FULL), 1'b1);
	endtask

	// config write, only called while nothing is in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = val[WW-1:0];
		else if (idx == REG_FRAME_HEIGHT)
			height_reg = val[HW-1:0];
		@(posedge clk);
	endtask

	// wait until every item is taken and every filtered pixel has come back
	task automatic settle();
		do
			@(posedge clk);
		while (outgoing_items.size() != 0 || in_valid || awaited_pixels.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// driver: pixel stream with random idle bursts
	always @(posedge clk) begin
		logic send;
		send = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready)
				advance_cross_filter(driven_item);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (outgoing_items.size() != 0 && !quiet_tail &&
						$urandom_range(99) < in_gap_pct) begin
					// idle this cycle and then while gap_left counts down
					gap_left = $urandom_range(8);
				end else if (outgoing_items.size() != 0) begin
					driven_item = outgoing_items.pop_front();
					send        = 1'b1;
				end
				in_valid <= send;
				if (send) begin
					drain    <= driven_item.drain;
					red_in   <= driven_item.px[0];
					green_in <= driven_item.px[1];
					blue_in  <= driven_item.px[2];
				end
			end
		end
	end

	// monitor: checks each filtered pixel against the oldest prediction, stalls at random
	always @(posedge clk) begin
		filtered_pixel_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_pixels.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: filtered pixel with none expected: r=%02h g=%02h b=%02h end=%0b",
							$time, red_out, green_out, blue_out, frame_end);
				end else begin
					want = awaited_pixels.pop_front();
					if (want.eof)
						frames_checked++;
					if (red_out !== want.px[0] || green_out !== want.px[1] ||
							blue_out !== want.px[2] || frame_end !== want.eof) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display({"%0t: mismatch, expected r=%02h g=%02h b=%02h end=%0b,",
								" got r=%02h g=%02h b=%02h end=%0b"}, $time,
								want.px[0], want.px[1], want.px[2], want.eof,
								red_out, green_out, blue_out, frame_end);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(99) < out_stall_pct) begin
				stall_left = $urandom_range(8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		pix_t        corner_set[9];
		int unsigned random_base, cols, rows, repeats;
		sample_style_t style;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed 3x3 frame: one interior pixel, saturated samples, ignored drains,
		// a pixel sent during the flush
		corner_set = '{24'h000000, 24'hFFFFFF, 24'h00FF00,
			24'hFFFFFF, 24'h00FF80, 24'hFF00FF,
			24'h123456, 24'h80007F, 24'hFFFFFF};
		write_reg(REG_FRAME_WIDTH, 16'd3);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		push_item(1'b1, make_pixel(SAMPLE_FULL), 1'b0);  // drain before the first pixel
		for (int k = 0; k < 9; k++) begin
			push_item(1'b0, corner_set[k], 1'b1);
			if (k == 4)
				push_item(1'b1, '1, 1'b0);  // drain in mid frame
		end
		for (int k = 0; k < 4; k++)
			push_item(k != 1, (k == 1) ? '1 : '0, 1'b1);
		settle();

		// zero in both registers acts as a 1x1 frame
		write_reg(REG_FRAME_WIDTH, 16'd0);
		write_reg(REG_FRAME_HEIGHT, 16'd0);
		push_item(1'b0, 24'hA55A3C, 1'b1);
		push_item(1'b1, '0, 1'b1);
		push_item(1'b0, 24'h00FF00, 1'b1);
		settle();

		// saturating register values: widest frame, then tallest frame
		in_gap_pct    = 20;
		out_stall_pct = 20;
		write_reg(REG_SPARE, 16'hFFFF);
		write_reg(REG_FRAME_WIDTH, 16'hFFFF);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		queue_frame(2, 20, SAMPLE_FULL);
		settle();
		write_reg(REG_FRAME_WIDTH, 16'd1);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		queue_frame(2, 20, SAMPLE_EXTREME);
		settle();

		// random frame sizes, mostly small, upper register bits random
		random_base = counted_items;
		while (counted_items - random_base < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 80)
				cols = $urandom_range(8, 1);
			else if ($urandom_range(99) < 75)
				cols = $urandom_range(20, 9);
			else
				cols = $urandom_range(64, 21);
			rows = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
			quiet_tail    = (counted_items - random_base + TAIL_ITEMS >= RANDOM_ITEMS);
			in_gap_pct    = quiet_tail ? 0 : 15 * $urandom_range(3);
			out_stall_pct = quiet_tail ? 0 : 15 * $urandom_range(3);
			write_reg(REG_FRAME_WIDTH, {5'($urandom), WW'(cols)});
			write_reg(REG_FRAME_HEIGHT, {3'($urandom), HW'(rows)});
			// same size frames back to back keep the line stores busy across frames
			repeats = $urandom_range(3, 1);
			for (int f = 0; f < repeats; f++) begin
				style = sample_style_t'($urandom_range(2));
				queue_frame($urandom_range(3) * 5, $urandom_range(2) * 20, style);
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (awaited_pixels.size() != 0) begin
			error_count += awaited_pixels.size();
			$display("%0d filtered pixels never came out", awaited_pixels.size());
		end
		$display("sent %0d stream items (%0d pixels), checked %0d filtered pixels in %0d frames",
			counted_items, pixels_sent, results_seen, frames_checked);
		$display("sizes from 1x1 up to 1024 wide and 4096 tall, %0d failures", error_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
hdl/crmf_pkg.sv
hdl/crmf_med5_lane.sv
hdl/crmf_line_buf.sv
hdl/crmf_divider.sv
hdl/cross_median_of_five_filter.sv
bench/cross_median_of_five_filter_tb.sv
